>>> rtl/core/mtrd_pkg.sv
package mtrd_pkg;

	localparam int TBL_DEPTH    = 624;
	localparam int TBL_AW       = 10;
	localparam int TWIST_OFFSET = 397;

	localparam logic [31:0] SEED_MULT    = 32'd69069;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
	localparam logic [30:0] LOW31        = 31'h7FFF_FFFF;
	localparam logic [33:0] WIDE_LIMIT   = 34'h0_4000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_SETUP,
		ST_MASK,
		ST_DRAW_RD,
		ST_DRAW_TMP,
		ST_DRAW_CHK,
		ST_REGEN_PRIME,
		ST_REGEN_RD,
		ST_REGEN_WR,
		ST_FINISH
	} state_t;

	// sequencer -> datapath
	typedef struct packed {
		logic idle;
		logic fill;
		logic setup;
		logic mask;
		logic draw_rd;
		logic draw_tmp;
		logic draw_chk;
		logic regen_prime;
		logic regen_rd;
		logic regen_wr;
		logic finish;
	} ctl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic in_valid;
		logic reseed_pending;
		logic raw;
		logic empty;
		logic wide;
		logic wl_zero;
		logic idx_last;
		logic draw_hit;
		logic out_free;
	} sts_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		return y ^ (y >> 18);
	endfunction

	function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] mixed;
		mixed = {a[31], b[30:0]};
		return (mixed >> 1) ^ (b[0] ? TWIST_MATRIX : 32'h0);
	endfunction

	// all ones at and below the highest set bit
	function automatic logic [30:0] smear(input logic [30:0] v);
		logic [30:0] m;
		m = v;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		m = m | (m >> 16);
		return m;
	endfunction

endpackage

>>> rtl/core/mtrd_table.sv
module mtrd_table (
	input  logic                          clk,
	input  logic                          we,
	input  logic [mtrd_pkg::TBL_AW-1:0]   waddr,
	input  logic [31:0]                   wdata,
	input  logic                          b_en,
	input  logic [mtrd_pkg::TBL_AW-1:0]   b_addr,
	output logic [31:0]                   b_data,
	input  logic                          c_en,
	input  logic [mtrd_pkg::TBL_AW-1:0]   c_addr,
	output logic [31:0]                   c_data
);

	logic [31:0] mem [mtrd_pkg::TBL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next enabled read
	always_ff @(posedge clk) begin
		if (b_en) begin
			b_data <= mem[b_addr];
		end
		if (c_en) begin
			c_data <= mem[c_addr];
		end
	end

endmodule

>>> rtl/core/mtrd_fsm.sv
module mtrd_fsm (
	input  logic            clk,
	input  logic            arst_n,
	input  mtrd_pkg::sts_t  sts,
	output mtrd_pkg::ctl_t  ctl
);

	mtrd_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtrd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			mtrd_pkg::ST_IDLE: begin
				if (sts.in_valid) begin
					state_nx = sts.reseed_pending ? mtrd_pkg::ST_FILL : mtrd_pkg::ST_SETUP;
				end
			end
			mtrd_pkg::ST_FILL: begin
				if (sts.idx_last) state_nx = mtrd_pkg::ST_SETUP;
			end
			mtrd_pkg::ST_SETUP: begin
				if (sts.raw) begin
					state_nx = mtrd_pkg::ST_DRAW_RD;
				end else if (sts.empty || sts.wide) begin
					state_nx = mtrd_pkg::ST_FINISH;
				end else begin
					state_nx = mtrd_pkg::ST_MASK;
				end
			end
			mtrd_pkg::ST_MASK:        state_nx = mtrd_pkg::ST_DRAW_RD;
			mtrd_pkg::ST_DRAW_RD: begin
				state_nx = sts.wl_zero ? mtrd_pkg::ST_REGEN_PRIME : mtrd_pkg::ST_DRAW_TMP;
			end
			mtrd_pkg::ST_DRAW_TMP:    state_nx = mtrd_pkg::ST_DRAW_CHK;
			mtrd_pkg::ST_DRAW_CHK: begin
				state_nx = sts.draw_hit ? mtrd_pkg::ST_FINISH : mtrd_pkg::ST_DRAW_RD;
			end
			mtrd_pkg::ST_REGEN_PRIME: state_nx = mtrd_pkg::ST_REGEN_RD;
			mtrd_pkg::ST_REGEN_RD:    state_nx = mtrd_pkg::ST_REGEN_WR;
			mtrd_pkg::ST_REGEN_WR: begin
				state_nx = sts.idx_last ? mtrd_pkg::ST_DRAW_RD : mtrd_pkg::ST_REGEN_RD;
			end
			mtrd_pkg::ST_FINISH: begin
				if (sts.out_free) state_nx = mtrd_pkg::ST_IDLE;
			end
			default:                  state_nx = mtrd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			mtrd_pkg::ST_IDLE:        ctl.idle        = 1'b1;
			mtrd_pkg::ST_FILL:        ctl.fill        = 1'b1;
			mtrd_pkg::ST_SETUP:       ctl.setup       = 1'b1;
			mtrd_pkg::ST_MASK:        ctl.mask        = 1'b1;
			mtrd_pkg::ST_DRAW_RD:     ctl.draw_rd     = 1'b1;
			mtrd_pkg::ST_DRAW_TMP:    ctl.draw_tmp    = 1'b1;
			mtrd_pkg::ST_DRAW_CHK:    ctl.draw_chk    = 1'b1;
			mtrd_pkg::ST_REGEN_PRIME: ctl.regen_prime = 1'b1;
			mtrd_pkg::ST_REGEN_RD:    ctl.regen_rd    = 1'b1;
			mtrd_pkg::ST_REGEN_WR:    ctl.regen_wr    = 1'b1;
			mtrd_pkg::ST_FINISH:      ctl.finish      = 1'b1;
			default:                  ctl             = '0;
		endcase
	end

endmodule

>>> rtl/core/mersenne_twister_ranged_draw.sv
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   kind, low_bound, high_bound, open_left, open_right
// result    out        out_valid / out_stall value, range_error
// config    in         cfg_we (no wait)      cfg_wdata -> seed
//
// A raw draw goes from request through setup, table read, temper and check to the result
// register; a ranged draw adds a mask step, and every rejected word repeats read, temper
// and check. Ranges that are empty or too wide go from setup straight to the finish step.
// Every 624 words the table is regenerated in place: the draw that finds it used up
// first primes a read, then runs one table entry per read/write pair through the shared
// twist unit on the two-read-port memory. After reset or a seed write the next request
// first fills the table, one multiply by 69069 per entry.
// The result register lets a new request in while a finished result is stalled.
module mersenne_twister_ranged_draw (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic               open_left,
	input  logic               open_right,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic               range_error
);

	localparam int AW = mtrd_pkg::TBL_AW;

	mtrd_pkg::ctl_t ctl;
	mtrd_pkg::sts_t sts;

	// configuration / generator state
	logic [31:0]   seed_q;
	logic          reseed_q;
	logic [AW-1:0] wl_q;       // words left in the table
	logic [AW-1:0] rp_q;       // next word to read
	logic [AW-1:0] idx_q;      // fill / regen index
	logic [31:0]   x_q;        // fill recurrence
	logic [31:0]   a_q;        // regen: current entry, old value

	// request registers
	logic               raw_q;
	logic signed [33:0] lo_q;
	logic signed [33:0] hi_q;
	logic [30:0]        span_q;
	logic [30:0]        mask_q;
	logic [30:0]        t_q;
	logic [31:0]        res_q;
	logic               err_q;

	// result register
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        err_out_q;

	// memory hookup
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          b_en;
	logic [AW-1:0] b_addr;
	logic [31:0]   b_data;
	logic          c_en;
	logic [AW-1:0] c_addr;
	logic [31:0]   c_data;

	logic               accept;
	logic               idx_last;
	logic               wl_zero;
	logic [AW-1:0]      draw_idx;
	logic [AW:0]        c_sum;
	logic [AW-1:0]      regen_c_addr;
	logic [AW-1:0]      regen_b_addr;
	logic signed [33:0] lo_in;
	logic signed [33:0] hi_in;
	logic signed [33:0] span_w;
	logic               empty;
	logic               wide;
	logic               hit;
	logic               out_free;
	logic [31:0]        tmp_word;   // tempered table word

	assign accept   = ctl.idle && in_valid;
	assign in_stall = !ctl.idle;
	assign out_free = !out_valid_q || !out_stall;

	assign idx_last = idx_q == AW'(mtrd_pkg::TBL_DEPTH - 1);
	assign wl_zero  = wl_q == '0;
	assign draw_idx = (rp_q >= AW'(mtrd_pkg::TBL_DEPTH)) ? '0 : rp_q;

	// regen reads entry i+1 and entry i+397, both wrapped at the table depth
	assign regen_b_addr = idx_last ? '0 : idx_q + AW'(1);
	assign c_sum        = {1'b0, idx_q} + (AW+1)'(mtrd_pkg::TWIST_OFFSET);
	assign regen_c_addr = (c_sum >= (AW+1)'(mtrd_pkg::TBL_DEPTH)) ?
		AW'(c_sum - (AW+1)'(mtrd_pkg::TBL_DEPTH)) : c_sum[AW-1:0];

	// bound adjustment in 34 bits so nothing wraps
	assign lo_in = {{2{low_bound[31]}}, low_bound} + 34'(open_left);
	assign hi_in = {{2{high_bound[31]}}, high_bound} + 34'(!open_right);

	assign span_w = hi_q - lo_q;
	assign empty  = !(lo_q < hi_q);
	assign wide   = span_w > $signed(mtrd_pkg::WIDE_LIMIT);
	assign hit    = raw_q || (t_q < span_q);

	assign tmp_word = mtrd_pkg::temper(c_data);

	always_comb begin
		sts                = '0;
		sts.in_valid       = in_valid;
		sts.reseed_pending = reseed_q;
		sts.raw            = raw_q;
		sts.empty          = empty;
		sts.wide           = wide;
		sts.wl_zero        = wl_zero;
		sts.idx_last       = idx_last;
		sts.draw_hit       = hit;
		sts.out_free       = out_free;
	end

	assign mem_we    = ctl.fill || ctl.regen_wr;
	assign mem_waddr = idx_q;
	assign mem_wdata = ctl.fill ? x_q : (c_data ^ mtrd_pkg::twist(a_q, b_data));
	assign b_en      = ctl.regen_prime || ctl.regen_rd;
	assign b_addr    = ctl.regen_prime ? '0 : regen_b_addr;
	assign c_en      = ctl.regen_rd || (ctl.draw_rd && !wl_zero);
	assign c_addr    = ctl.regen_rd ? regen_c_addr : draw_idx;

	mtrd_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	mtrd_table u_table (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.b_en   (b_en),
		.b_addr (b_addr),
		.b_data (b_data),
		.c_en   (c_en),
		.c_addr (c_addr),
		.c_data (c_data)
	);

	// generator control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= 32'd1;
			reseed_q <= 1'b1;
			wl_q     <= '0;
			rp_q     <= AW'(1);
		end else begin
			if (ctl.fill && idx_last) begin
				wl_q     <= '0;
				rp_q     <= AW'(1);
				reseed_q <= 1'b0;
			end
			// end of regen: leave the pointers so the next read takes entry 0
			if (ctl.regen_wr && idx_last) begin
				wl_q <= AW'(mtrd_pkg::TBL_DEPTH);
				rp_q <= '0;
			end
			if (ctl.draw_rd && !wl_zero) begin
				wl_q <= wl_q - AW'(1);
				rp_q <= draw_idx + AW'(1);
			end
			if (cfg_we) begin
				seed_q   <= cfg_wdata;
				reseed_q <= 1'b1;
			end
		end
	end

	// shared index and fill/twist datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= seed_q | 32'd1;
			idx_q <= '0;
		end
		if (ctl.fill) begin
			x_q   <= x_q * mtrd_pkg::SEED_MULT;
			idx_q <= idx_q + AW'(1);
		end
		if (ctl.regen_prime) begin
			idx_q <= '0;
		end
		if (ctl.regen_rd) begin
			a_q <= b_data;
		end
		if (ctl.regen_wr) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			raw_q <= !kind;
			lo_q  <= kind ? lo_in : '0;
			hi_q  <= hi_in;
		end
		if (ctl.setup) begin
			span_q <= span_w[30:0];
			mask_q <= mtrd_pkg::LOW31;
			res_q  <= lo_q[31:0];
			err_q  <= !empty && wide;
		end
		if (ctl.mask) begin
			mask_q <= mtrd_pkg::smear(span_q - 31'd1);
		end
		if (ctl.draw_tmp) begin
			t_q <= tmp_word[30:0] & mask_q;
		end
		if (ctl.draw_chk && hit) begin
			res_q <= lo_q[31:0] + {1'b0, t_q};
			err_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish && out_free) begin
			value_q   <= res_q;
			err_out_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign range_error = err_out_q;

endmodule

>>> rtl/core/mtrd_chk.sv
module mtrd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value,
	input logic        range_error
);

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(range_error))
		else $error("stalled result changed");

	// one request at a time: busy right after a request is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("request taken while busy");

	// no result can appear the cycle after a request
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result too early");

	// going idle means a result was just loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_stall) |-> out_valid)
		else $error("idle without result");

endmodule

bind mersenne_twister_ranged_draw mtrd_chk u_mtrd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.value       (value),
	.range_error (range_error)
);

>>> bench/mtrd_tb_pkg.sv
`timescale 1ns / 100ps

package mtrd_tb_pkg;

	typedef enum logic {
		KIND_RAW    = 1'b0,
		KIND_RANGED = 1'b1
	} draw_kind_t;

endpackage

>>> bench/mt_draw_checker.sv
`timescale 1ns / 100ps

module mt_draw_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               kind,
	input  logic signed [31:0] low_bound,
	input  logic signed [31:0] high_bound,
	input  logic               open_left,
	input  logic               open_right,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] value,
	input  logic               range_error,
	output int                 mismatch_count,
	output int                 pending_draws
);

	typedef struct packed {
		logic [31:0] value;
		logic        range_error;
	} draw_result_t;

	// generator state
	bit [31:0]   mt_words [mtrd_pkg::TBL_DEPTH];
	int unsigned words_left;
	int unsigned read_ptr;
	bit          reseed_due;
	bit [31:0]   seed_reg;

	draw_result_t expected_draws [$];
	int           result_num;

	function automatic void seed_table();
		bit [31:0] x;
		x = seed_reg | 32'd1;
		mt_words[0] = x;
		for (int i = 1; i < mtrd_pkg::TBL_DEPTH; i++) begin
			x = x * mtrd_pkg::SEED_MULT;
			mt_words[i] = x;
		end
		words_left = 0;
		read_ptr   = 1;
		reseed_due = 1'b0;
	endfunction

	// in-place twist; modulo indexing reproduces the usual three-loop order
	function automatic void reload_table();
		bit [31:0] a, b, m;
		for (int i = 0; i < mtrd_pkg::TBL_DEPTH; i++) begin
			a = mt_words[i];
			b = mt_words[(i + 1) % mtrd_pkg::TBL_DEPTH];
			m = {a[31], b[30:0]};
			mt_words[i] = mt_words[(i + mtrd_pkg::TWIST_OFFSET) % mtrd_pkg::TBL_DEPTH]
				^ (m >> 1) ^ (b[0] ? mtrd_pkg::TWIST_MATRIX : 32'h0);
		end
	endfunction

	function automatic bit [31:0] next_word();
		bit [31:0]   y;
		int unsigned idx;
		if (words_left == 0) begin
			reload_table();
			words_left = mtrd_pkg::TBL_DEPTH - 1;
			read_ptr   = 1;
			y = mt_words[0];
		end else begin
			words_left--;
			idx = read_ptr;
			if (idx >= mtrd_pkg::TBL_DEPTH)
				idx = 0;
			read_ptr = (idx + 1) & 10'h3FF;
			y = mt_words[idx];
		end
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtrd_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtrd_pkg::TEMPER_C);
		return y ^ (y >> 18);
	endfunction

	function automatic draw_result_t predict_draw(logic k, logic signed [31:0] lo_in,
			logic signed [31:0] hi_in, logic ol, logic orr);
		draw_result_t r;
		longint       lo, hi, span;
		bit [31:0]    mask, t;
		if (reseed_due)
			seed_table();
		r.range_error = 1'b0;
		if (k == mtrd_tb_pkg::KIND_RAW) begin
			r.value = next_word() & 32'h7FFF_FFFF;
		end else begin
			lo = longint'(lo_in);
			hi = longint'(hi_in);
			if (ol)
				lo++;
			if (!orr)
				hi++;
			r.value = lo[31:0];
			if (lo < hi) begin
				span = hi - lo;
				if (span > longint'(mtrd_pkg::WIDE_LIMIT)) begin
					r.range_error = 1'b1;
				end else begin
					mask = 0;
					while (longint'(mask) < span - 1)
						mask = mask * 2 + 1;
					do
						t = next_word() & 32'h7FFF_FFFF & mask;
					while (longint'(t) >= span);
					lo = lo + longint'(t);
					r.value = lo[31:0];
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		draw_result_t want;
		if (!arst_n) begin
			seed_reg       = 32'd1;
			reseed_due     = 1'b1;
			words_left     = 0;
			read_ptr       = 1;
			mismatch_count = 0;
			result_num     = 0;
			expected_draws.delete();
		end else begin
			if (cfg_we) begin
				seed_reg   = cfg_wdata;
				reseed_due = 1'b1;
			end
			if (in_valid && !in_stall)
				expected_draws.push_back(predict_draw(kind, low_bound, high_bound,
					open_left, open_right));
			if (out_valid && !out_stall) begin
				if (expected_draws.size() == 0) begin
					if (mismatch_count < 10)
						$display("result %0d: none expected, got value %h err %b",
							result_num, value, range_error);
					mismatch_count++;
				end else begin
					want = expected_draws.pop_front();
					if (value !== want.value || range_error !== want.range_error) begin
						if (mismatch_count < 10)
							$display("result %0d: expected value %h err %b, got value %h err %b",
								result_num, want.value, want.range_error, value, range_error);
						mismatch_count++;
					end
				end
				result_num++;
			end
		end
		pending_draws = expected_draws.size();
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam mtrd_tb_pkg::draw_kind_t KIND_RAW    = mtrd_tb_pkg::KIND_RAW;
	localparam mtrd_tb_pkg::draw_kind_t KIND_RANGED = mtrd_tb_pkg::KIND_RANGED;

	localparam logic signed [31:0] INT_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] SPAN_2_30 = 32'sh4000_0000;
	// longest legal quiet stretch: table fill plus a full regeneration plus a long
	// rejection run under heavy output stall; this is several times that
	localparam int QUIET_LIMIT = 20000;
	localparam int NUM_PHASES  = 7;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [31:0]        cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               kind = KIND_RAW;
	logic signed [31:0] low_bound = '0;
	logic signed [31:0] high_bound = '0;
	logic               open_left = 1'b0;
	logic               open_right = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] value;
	logic               range_error;

	int         mismatch_count;
	int         pending_draws;
	int         quiet_cycles = 0;
	idle_mode_t idle_mode = IDLE_NONE;

	// per-phase seeds and request counts; the long phases run past 624 words so the
	// table regenerates at least once with and once without idling
	bit [31:0] phase_seed [NUM_PHASES];
	int        phase_items [NUM_PHASES] = '{500, 150, 150, 450, 100, 100, 50};

	mersenne_twister_ranged_draw DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.low_bound   (low_bound),
		.high_bound  (high_bound),
		.open_left   (open_left),
		.open_right  (open_right),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.range_error (range_error)
	);

	mt_draw_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.low_bound      (low_bound),
		.high_bound     (high_bound),
		.open_left      (open_left),
		.open_right     (open_right),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.range_error    (range_error),
		.mismatch_count (mismatch_count),
		.pending_draws  (pending_draws)
	);

	// 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Result side stalls at the falling edge only, so the DUT sees a steady value
	// across each rising edge. Heavy stall in receiver mode, light in the mixed one.
	always @(negedge clk) begin
		case (idle_mode)
			IDLE_RECEIVER: begin
				out_stall <= ($urandom_range(99) < 71);
			end
			IDLE_BOTH: begin
				out_stall <= ($urandom_range(99) < 14);
			end
			default: begin
				out_stall <= 1'b0;
			end
		endcase
	end

	// Watchdog: any request or result moving resets the quiet counter.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic bit sender_waits();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 71;
			IDLE_BOTH:   return $urandom_range(99) < 14;
			default:     return 1'b0;
		endcase
	endfunction

	// Present one request from a falling edge and hold it until accepted; returns on
	// the falling edge after acceptance. Valid stays high into the next request
	// unless the sender chooses to idle there.
	task automatic issue_request(mtrd_tb_pkg::draw_kind_t k, logic signed [31:0] lo,
			logic signed [31:0] hi, bit left_open, bit right_open);
		while (sender_waits()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		low_bound  <= lo;
		high_bound <= hi;
		open_left  <= left_open;
		open_right <= right_open;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sender goes quiet until every outstanding result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_draws != 0);
	endtask

	task automatic write_seed(bit [31:0] s);
		cfg_we    <= 1'b1;
		cfg_wdata <= s;
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_edge();
		case ($urandom_range(7))
			0: return INT_MIN;
			1: return INT_MIN + 1;
			2: return -1;
			3: return 0;
			4: return 1;
			5: return INT_MAX - 1;
			6: return SPAN_2_30;
			default: return INT_MAX;
		endcase
	endfunction

	// Half are in-range ranged requests (small spans reject often, medium spans sit
	// around the 2^30 width boundary); the rest are raw draws, fully random bounds that
	// are often empty or too wide, and corner values.
	task automatic random_request();
		int                      pick;
		longint                  hi_wide;
		logic signed [31:0]      lo, hi;
		mtrd_tb_pkg::draw_kind_t k;
		pick = $urandom_range(99);
		lo   = $urandom;
		hi   = $urandom;
		k    = KIND_RANGED;
		if (pick < 30) begin
			k = KIND_RAW;
		end else if (pick < 65) begin
			hi_wide = longint'(lo) + longint'($urandom_range(42)) - 2;
			if (hi_wide > longint'(INT_MAX))
				hi_wide = INT_MAX;
			hi = hi_wide[31:0];
		end else if (pick < 80) begin
			if ($urandom_range(1))
				hi_wide = longint'(lo) + longint'($urandom_range(32'h4000_0002));
			else
				hi_wide = longint'(lo) + longint'(SPAN_2_30) - 3 + $urandom_range(5);
			if (hi_wide > longint'(INT_MAX))
				hi_wide = INT_MAX;
			hi = hi_wide[31:0];
		end else if (pick >= 92) begin
			lo = pick_edge();
			hi = pick_edge();
		end
		issue_request(k, lo, hi, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	initial begin
		phase_seed[0] = 32'h0000_0000;
		phase_seed[1] = 32'hFFFF_FFFF;
		phase_seed[2] = 32'd4357;
		phase_seed[3] = $urandom;
		phase_seed[4] = 32'h8000_0000;
		phase_seed[5] = $urandom;
		phase_seed[6] = 32'd1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests on the reset seed, no idling.
		issue_request(KIND_RAW, 0, 0, 0, 0);
		issue_request(KIND_RAW, 0, 0, 0, 0);
		issue_request(KIND_RANGED, 0, 0, 0, 0);                  // span of one
		issue_request(KIND_RANGED, 5, 5, 1, 0);                  // empty, lower bump
		issue_request(KIND_RANGED, 5, 5, 0, 1);                  // empty, upper open
		issue_request(KIND_RANGED, 10, 3, 0, 0);                 // reversed bounds
		issue_request(KIND_RANGED, INT_MIN, INT_MAX, 0, 0);      // full width, error
		issue_request(KIND_RANGED, INT_MAX, INT_MAX, 1, 0);      // lower bump past 2^31-1
		issue_request(KIND_RANGED, INT_MAX - 9, INT_MAX, 0, 0);  // upper bump past 2^31-1
		issue_request(KIND_RANGED, INT_MIN, INT_MIN, 0, 0);
		issue_request(KIND_RANGED, INT_MIN, INT_MIN, 0, 1);
		issue_request(KIND_RANGED, 0, SPAN_2_30 - 1, 0, 0);      // span exactly 2^30
		issue_request(KIND_RANGED, 0, SPAN_2_30, 0, 0);          // one past the limit
		issue_request(KIND_RANGED, -1, SPAN_2_30 - 1, 1, 0);
		issue_request(KIND_RANGED, 0, SPAN_2_30, 0, 1);
		issue_request(KIND_RANGED, -100, 100, 1, 1);
		issue_request(KIND_RANGED, 1, 2, 0, 0);
		issue_request(KIND_RANGED, 1, 3, 0, 0);
		issue_request(KIND_RANGED, INT_MAX - SPAN_2_30, INT_MAX, 0, 0);
		issue_request(KIND_RANGED, INT_MIN, INT_MIN + SPAN_2_30 - 1, 0, 0);
		issue_request(KIND_RAW, -1, -1, 1, 1);                   // bounds ignored
		issue_request(KIND_RANGED, 0, 0, 1, 1);                  // empty, both open

		// Random phases, each with its own seed and idling pattern. Seeds change
		// only with nothing in flight; one phase writes the seed twice in a row.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			if (p == NUM_PHASES - 1)
				write_seed($urandom);
			write_seed(phase_seed[p]);
			cfg_we    <= 1'b0;
			idle_mode <= idle_mode_t'(p % 4);
			for (int n = 0; n < phase_items[p]; n++) begin
				random_request();
				if ($urandom_range(199) == 0)
					drain_results();
			end
		end

		drain_results();
		idle_mode <= IDLE_NONE;
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pending_draws == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/mtrd_pkg.sv
rtl/core/mtrd_table.sv
rtl/core/mtrd_fsm.sv
rtl/core/mersenne_twister_ranged_draw.sv
rtl/core/mtrd_chk.sv
bench/mtrd_tb_pkg.sv
bench/mt_draw_checker.sv
bench/testbench.sv
